// File: src/altered_face_quality_histogram_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the altered face quality histogram
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ALTERED_FACE_QUALITY_HISTOGRAM_TOP_DEFINES_SVH
`define ALTERED_FACE_QUALITY_HISTOGRAM_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFQH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AFQH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/afqh_pkg.sv
// ----------------------------------------------------------------------------
// Altered face quality histogram package
// Sizes, codes, beat types and arithmetic helpers for the histogram block.
// ----------------------------------------------------------------------------
package afqh_pkg;

    localparam int QUALITY_BINS = 1000;
    localparam int SIDE_BINS    = 48;
    localparam int COUNT_BITS   = 24;

    localparam int Q_W      = 17;
    localparam int PROD_W   = 2 * Q_W;
    localparam int SUM_W    = 41;
    localparam int SQ_W     = 57;
    localparam int DATA_W   = 57;
    localparam int SIDE_W   = 8;
    localparam int IDX_W    = 10;
    localparam int QB_W     = $clog2(QUALITY_BINS);
    localparam int SB_W     = $clog2(SIDE_BINS);
    localparam int QB_PROD_W = Q_W + $clog2(QUALITY_BINS + 1);
    localparam int CLR_LEN  = (QUALITY_BINS > SIDE_BINS) ? QUALITY_BINS : SIDE_BINS;
    localparam int CLR_W    = $clog2(CLR_LEN);
    localparam int SCALAR_COUNT = 13;

    localparam logic [Q_W-1:0]    Q_ONE      = 17'h10000;
    localparam logic [Q_W-1:0]    EXT_ONES   = 17'h1FFFF;
    localparam logic [SIDE_W-1:0] FIRST_SIDE_RESET = 8'd3;

    localparam logic [1:0] REQ_FACE   = 2'd0;
    localparam logic [1:0] REQ_VERTEX = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    localparam logic [1:0] BANK_STAB   = 2'd0;
    localparam logic [1:0] BANK_SHAPE  = 2'd1;
    localparam logic [1:0] BANK_SIDES  = 2'd2;
    localparam logic [1:0] BANK_SCALAR = 2'd3;

    localparam logic [3:0] SC_FACE_TOTAL     = 4'd0;
    localparam logic [3:0] SC_VERTEX_TOTAL   = 4'd1;
    localparam logic [3:0] SC_ALT_FACE_TOTAL = 4'd2;
    localparam logic [3:0] SC_ALT_VERT_TOTAL = 4'd3;
    localparam logic [3:0] SC_STAB_MIN       = 4'd4;
    localparam logic [3:0] SC_STAB_MAX       = 4'd5;
    localparam logic [3:0] SC_SHAPE_MIN      = 4'd6;
    localparam logic [3:0] SC_SHAPE_MAX      = 4'd7;
    localparam logic [3:0] SC_STAB_SUM       = 4'd8;
    localparam logic [3:0] SC_SHAPE_SUM      = 4'd9;
    localparam logic [3:0] SC_STAB_SQ_SUM    = 4'd10;
    localparam logic [3:0] SC_SHAPE_SQ_SUM   = 4'd11;

    typedef struct packed {
        logic [1:0]        req_type;
        logic              altered;
        logic [Q_W-1:0]    stability_q;
        logic [Q_W-1:0]    shape_q;
        logic [SIDE_W-1:0] side_count;
        logic [1:0]        read_bank;
        logic [IDX_W-1:0]  read_index;
    } afqh_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              read_status;
    } afqh_out_t;

    function automatic logic [Q_W-1:0] sat_quality(input logic [Q_W-1:0] q);
        return (q > Q_ONE) ? Q_ONE : q;
    endfunction

    function automatic logic [QB_W-1:0] quality_bin(input logic [Q_W-1:0] q);
        logic [QB_PROD_W-1:0] prod;
        logic [QB_PROD_W-1:0] bin;
        prod = QB_PROD_W'(q) * QB_PROD_W'(QUALITY_BINS);
        bin  = prod >> 16;
        if (bin >= QB_PROD_W'(QUALITY_BINS))
        begin
            bin = QB_PROD_W'(QUALITY_BINS - 1);
        end
        return bin[QB_W-1:0];
    endfunction

    function automatic logic [SB_W-1:0] side_bin(input logic [SIDE_W-1:0] sides,
                                                 input logic [SIDE_W-1:0] first);
        logic [SIDE_W:0] diff;
        diff = {1'b0, sides} - {1'b0, first};
        if (sides <= first)
        begin
            diff = '0;
        end
        else if (diff >= (SIDE_W + 1)'(SIDE_BINS))
        begin
            diff = (SIDE_W + 1)'(SIDE_BINS - 1);
        end
        return diff[SB_W-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add_sum(input logic [SUM_W-1:0] a,
                                                     input logic [Q_W-1:0]   b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W + 1)'(b);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic logic [SQ_W-1:0] sat_add_sq(input logic [SQ_W-1:0]   a,
                                                   input logic [PROD_W-1:0] b);
        logic [SQ_W:0] s;
        s = {1'b0, a} + (SQ_W + 1)'(b);
        return s[SQ_W] ? {SQ_W{1'b1}} : s[SQ_W-1:0];
    endfunction

endpackage

// File: src/altered_face_quality_histogram_top.sv
// ----------------------------------------------------------------------------
// Altered face quality histogram, top level
// Counts faces and vertices, keeps extremes and moment sums of the two face
// qualities, and bins altered faces into two quality histograms and a side
// count histogram held in block memories, with read-back of any value.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle on req, whatever its type, while
// req_ready is high. Each beat passes an input register stage, in which its
// bins are addressed and read from the memories, and a read-modify-write
// stage; a read beat's result is then registered in the rsp register, and
// the last write is forwarded to a read of the same bin. Only a read that
// finds the rsp register still full holds the pipeline. After reset the
// histogram memories are cleared one bin a cycle; req_ready stays low until
// the clearing pass ends, while configuration writes are taken as ever.
// ----------------------------------------------------------------------------
`include "altered_face_quality_histogram_top_defines.svh"

module altered_face_quality_histogram_top
    import afqh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  afqh_in_t          req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output afqh_out_t         rsp,
    input  logic              cfg_wr_en,
    input  logic [SIDE_W-1:0] cfg_wr_data
);

    logic [SIDE_W-1:0] first_side_reg;
    logic              clearing_reg;
    logic [CLR_W-1:0]  clr_cnt_reg;

    logic              stall;
    logic              advance;
    logic              accept;

    logic              s1_valid_reg;
    logic [1:0]        s1_req_reg;
    logic              s1_alt_reg;
    logic [Q_W-1:0]    s1_qs_reg;
    logic [Q_W-1:0]    s1_qg_reg;
    logic [SIDE_W-1:0] s1_side_reg;
    logic [1:0]        s1_bank_reg;
    logic [IDX_W-1:0]  s1_idx_reg;

    logic [QB_W-1:0]   s1_stab_addr;
    logic [QB_W-1:0]   s1_shape_addr;
    logic [SB_W-1:0]   s1_sides_addr;
    logic              s1_oob;

    logic              s2_valid_reg;
    logic [1:0]        s2_req_reg;
    logic              s2_alt_reg;
    logic [Q_W-1:0]    s2_qs_reg;
    logic [Q_W-1:0]    s2_qg_reg;
    logic [QB_W-1:0]   s2_stab_addr_reg;
    logic [QB_W-1:0]   s2_shape_addr_reg;
    logic [SB_W-1:0]   s2_sides_addr_reg;
    logic [1:0]        s2_bank_reg;
    logic [3:0]        s2_sidx_reg;
    logic              s2_oob_reg;
    logic [PROD_W-1:0] s2_sq_s_reg;
    logic [PROD_W-1:0] s2_sq_g_reg;
    logic [PROD_W-1:0] s2_cross_reg;

    logic [COUNT_BITS-1:0] stab_mem  [QUALITY_BINS];
    logic [COUNT_BITS-1:0] shape_mem [QUALITY_BINS];
    logic [COUNT_BITS-1:0] sides_mem [SIDE_BINS];
    logic [COUNT_BITS-1:0] stab_rd_reg;
    logic [COUNT_BITS-1:0] shape_rd_reg;
    logic [COUNT_BITS-1:0] sides_rd_reg;

    logic                  lw_stab_en_reg;
    logic                  lw_shape_en_reg;
    logic                  lw_sides_en_reg;
    logic [QB_W-1:0]       lw_stab_addr_reg;
    logic [QB_W-1:0]       lw_shape_addr_reg;
    logic [SB_W-1:0]       lw_sides_addr_reg;
    logic [COUNT_BITS-1:0] lw_stab_data_reg;
    logic [COUNT_BITS-1:0] lw_shape_data_reg;
    logic [COUNT_BITS-1:0] lw_sides_data_reg;

    logic [COUNT_BITS-1:0] stab_cur;
    logic [COUNT_BITS-1:0] shape_cur;
    logic [COUNT_BITS-1:0] sides_cur;
    logic [COUNT_BITS-1:0] stab_inc;
    logic [COUNT_BITS-1:0] shape_inc;
    logic [COUNT_BITS-1:0] sides_inc;

    logic                  s2_face;
    logic                  s2_face_alt;
    logic                  s2_vertex;
    logic                  s2_read;

    logic                  stab_we;
    logic                  shape_we;
    logic                  sides_we;
    logic [QB_W-1:0]       stab_waddr;
    logic [QB_W-1:0]       shape_waddr;
    logic [SB_W-1:0]       sides_waddr;
    logic [COUNT_BITS-1:0] stab_wdata;
    logic [COUNT_BITS-1:0] shape_wdata;
    logic [COUNT_BITS-1:0] sides_wdata;

    logic [COUNT_BITS-1:0] face_total_reg;
    logic [COUNT_BITS-1:0] vertex_total_reg;
    logic [COUNT_BITS-1:0] alt_face_total_reg;
    logic [COUNT_BITS-1:0] alt_vert_total_reg;
    logic [Q_W-1:0]        stab_min_reg;
    logic [Q_W-1:0]        stab_max_reg;
    logic [Q_W-1:0]        shape_min_reg;
    logic [Q_W-1:0]        shape_max_reg;
    logic [SUM_W-1:0]      stab_sum_reg;
    logic [SUM_W-1:0]      shape_sum_reg;
    logic [SQ_W-1:0]       stab_sq_sum_reg;
    logic [SQ_W-1:0]       shape_sq_sum_reg;
    logic [SQ_W-1:0]       cross_sum_reg;

    logic [COUNT_BITS-1:0] face_total_next;
    logic [COUNT_BITS-1:0] vertex_total_next;
    logic [COUNT_BITS-1:0] alt_face_total_next;
    logic [COUNT_BITS-1:0] alt_vert_total_next;
    logic [Q_W-1:0]        stab_min_next;
    logic [Q_W-1:0]        stab_max_next;
    logic [Q_W-1:0]        shape_min_next;
    logic [Q_W-1:0]        shape_max_next;
    logic [SUM_W-1:0]      stab_sum_next;
    logic [SUM_W-1:0]      shape_sum_next;
    logic [SQ_W-1:0]       stab_sq_sum_next;
    logic [SQ_W-1:0]       shape_sq_sum_next;
    logic [SQ_W-1:0]       cross_sum_next;

    logic [DATA_W-1:0]     scalar_sel;
    logic [DATA_W-1:0]     read_value;

    logic                  rsp_valid_reg;
    afqh_out_t             rsp_reg;

    // Handshake and pipeline control.
    assign s2_face     = s2_valid_reg && (s2_req_reg == REQ_FACE);
    assign s2_face_alt = s2_face && s2_alt_reg;
    assign s2_vertex   = s2_valid_reg && (s2_req_reg == REQ_VERTEX);
    assign s2_read     = s2_valid_reg && (s2_req_reg == REQ_READ);

    assign stall     = rsp_valid_reg && !rsp_ready && s2_read;
    assign advance   = !stall;
    assign req_ready = !clearing_reg && !stall;
    assign accept    = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_side_reg <= FIRST_SIDE_RESET;
        end
        else if (cfg_wr_en)
        begin
            first_side_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CLR_W'(CLR_LEN - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept && ((req.req_type == REQ_FACE)
                                       || (req.req_type == REQ_VERTEX)
                                       || (req.req_type == REQ_READ));
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg  <= req.req_type;
            s1_alt_reg  <= req.altered;
            s1_qs_reg   <= sat_quality(req.stability_q);
            s1_qg_reg   <= sat_quality(req.shape_q);
            s1_side_reg <= req.side_count;
            s1_bank_reg <= req.read_bank;
            s1_idx_reg  <= req.read_index;
        end
    end

    // Bin addresses and range check.
    always_comb
    begin
        if (s1_req_reg == REQ_READ)
        begin
            s1_stab_addr  = QB_W'(s1_idx_reg);
            s1_shape_addr = QB_W'(s1_idx_reg);
            s1_sides_addr = SB_W'(s1_idx_reg);
        end
        else
        begin
            s1_stab_addr  = quality_bin(s1_qs_reg);
            s1_shape_addr = quality_bin(s1_qg_reg);
            s1_sides_addr = side_bin(s1_side_reg, first_side_reg);
        end
        case (s1_bank_reg)
            BANK_STAB, BANK_SHAPE: s1_oob = (32'(s1_idx_reg) >= QUALITY_BINS);
            BANK_SIDES:            s1_oob = (32'(s1_idx_reg) >= SIDE_BINS);
            default:               s1_oob = (32'(s1_idx_reg) >= SCALAR_COUNT);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_req_reg        <= s1_req_reg;
            s2_alt_reg        <= s1_alt_reg;
            s2_qs_reg         <= s1_qs_reg;
            s2_qg_reg         <= s1_qg_reg;
            s2_stab_addr_reg  <= s1_stab_addr;
            s2_shape_addr_reg <= s1_shape_addr;
            s2_sides_addr_reg <= s1_sides_addr;
            s2_bank_reg       <= s1_bank_reg;
            s2_sidx_reg       <= s1_idx_reg[3:0];
            s2_oob_reg        <= s1_oob;
            s2_sq_s_reg       <= PROD_W'(s1_qs_reg) * PROD_W'(s1_qs_reg);
            s2_sq_g_reg       <= PROD_W'(s1_qg_reg) * PROD_W'(s1_qg_reg);
            s2_cross_reg      <= PROD_W'(s1_qs_reg) * PROD_W'(s1_qg_reg);
        end
    end

    // Histogram memories: read in the address stage, written back in the read-modify-write stage.
    assign stab_we     = clearing_reg || (advance && s2_face_alt);
    assign shape_we    = clearing_reg || (advance && s2_face_alt);
    assign sides_we    = (clearing_reg && (32'(clr_cnt_reg) < SIDE_BINS))
                         || (advance && s2_face_alt);
    assign stab_waddr  = clearing_reg ? clr_cnt_reg[QB_W-1:0] : s2_stab_addr_reg;
    assign shape_waddr = clearing_reg ? clr_cnt_reg[QB_W-1:0] : s2_shape_addr_reg;
    assign sides_waddr = clearing_reg ? clr_cnt_reg[SB_W-1:0] : s2_sides_addr_reg;
    assign stab_wdata  = clearing_reg ? '0 : stab_inc;
    assign shape_wdata = clearing_reg ? '0 : shape_inc;
    assign sides_wdata = clearing_reg ? '0 : sides_inc;

    always_ff @(posedge clk)
    begin
        if (stab_we)
        begin
            stab_mem[stab_waddr] <= stab_wdata;
        end
        if (advance)
        begin
            stab_rd_reg <= stab_mem[s1_stab_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (shape_we)
        begin
            shape_mem[shape_waddr] <= shape_wdata;
        end
        if (advance)
        begin
            shape_rd_reg <= shape_mem[s1_shape_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sides_we)
        begin
            sides_mem[sides_waddr] <= sides_wdata;
        end
        if (advance)
        begin
            sides_rd_reg <= sides_mem[s1_sides_addr];
        end
    end

    // The write of the beat just ahead lands on the same edge as this beat's
    // read, so the memory returns the old bin and the written value is used.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_stab_en_reg  <= 1'b0;
            lw_shape_en_reg <= 1'b0;
            lw_sides_en_reg <= 1'b0;
        end
        else if (advance)
        begin
            lw_stab_en_reg  <= s2_face_alt;
            lw_shape_en_reg <= s2_face_alt;
            lw_sides_en_reg <= s2_face_alt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lw_stab_addr_reg  <= s2_stab_addr_reg;
            lw_shape_addr_reg <= s2_shape_addr_reg;
            lw_sides_addr_reg <= s2_sides_addr_reg;
            lw_stab_data_reg  <= stab_inc;
            lw_shape_data_reg <= shape_inc;
            lw_sides_data_reg <= sides_inc;
        end
    end

    always_comb
    begin
        stab_cur  = (lw_stab_en_reg && (lw_stab_addr_reg == s2_stab_addr_reg))
                    ? lw_stab_data_reg : stab_rd_reg;
        shape_cur = (lw_shape_en_reg && (lw_shape_addr_reg == s2_shape_addr_reg))
                    ? lw_shape_data_reg : shape_rd_reg;
        sides_cur = (lw_sides_en_reg && (lw_sides_addr_reg == s2_sides_addr_reg))
                    ? lw_sides_data_reg : sides_rd_reg;
        stab_inc  = sat_inc(stab_cur);
        shape_inc = sat_inc(shape_cur);
        sides_inc = sat_inc(sides_cur);
    end

    // Counters, extremes and moment sums.
    always_comb
    begin
        face_total_next     = face_total_reg;
        vertex_total_next   = vertex_total_reg;
        alt_face_total_next = alt_face_total_reg;
        alt_vert_total_next = alt_vert_total_reg;
        stab_min_next       = stab_min_reg;
        stab_max_next       = stab_max_reg;
        shape_min_next      = shape_min_reg;
        shape_max_next      = shape_max_reg;
        stab_sum_next       = stab_sum_reg;
        shape_sum_next      = shape_sum_reg;
        stab_sq_sum_next    = stab_sq_sum_reg;
        shape_sq_sum_next   = shape_sq_sum_reg;
        cross_sum_next      = cross_sum_reg;
        if (s2_face)
        begin
            face_total_next = sat_inc(face_total_reg);
        end
        if (s2_face_alt)
        begin
            alt_face_total_next = sat_inc(alt_face_total_reg);
            stab_min_next       = (s2_qs_reg < stab_min_reg) ? s2_qs_reg : stab_min_reg;
            stab_max_next       = (s2_qs_reg > stab_max_reg) ? s2_qs_reg : stab_max_reg;
            shape_min_next      = (s2_qg_reg < shape_min_reg) ? s2_qg_reg : shape_min_reg;
            shape_max_next      = (s2_qg_reg > shape_max_reg) ? s2_qg_reg : shape_max_reg;
            stab_sum_next       = sat_add_sum(stab_sum_reg, s2_qs_reg);
            shape_sum_next      = sat_add_sum(shape_sum_reg, s2_qg_reg);
            stab_sq_sum_next    = sat_add_sq(stab_sq_sum_reg, s2_sq_s_reg);
            shape_sq_sum_next   = sat_add_sq(shape_sq_sum_reg, s2_sq_g_reg);
            cross_sum_next      = sat_add_sq(cross_sum_reg, s2_cross_reg);
        end
        if (s2_vertex)
        begin
            vertex_total_next = sat_inc(vertex_total_reg);
            if (s2_alt_reg)
            begin
                alt_vert_total_next = sat_inc(alt_vert_total_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_total_reg     <= '0;
            vertex_total_reg   <= '0;
            alt_face_total_reg <= '0;
            alt_vert_total_reg <= '0;
            stab_min_reg       <= EXT_ONES;
            stab_max_reg       <= '0;
            shape_min_reg      <= EXT_ONES;
            shape_max_reg      <= '0;
            stab_sum_reg       <= '0;
            shape_sum_reg      <= '0;
            stab_sq_sum_reg    <= '0;
            shape_sq_sum_reg   <= '0;
            cross_sum_reg      <= '0;
        end
        else if (advance)
        begin
            face_total_reg     <= face_total_next;
            vertex_total_reg   <= vertex_total_next;
            alt_face_total_reg <= alt_face_total_next;
            alt_vert_total_reg <= alt_vert_total_next;
            stab_min_reg       <= stab_min_next;
            stab_max_reg       <= stab_max_next;
            shape_min_reg      <= shape_min_next;
            shape_max_reg      <= shape_max_next;
            stab_sum_reg       <= stab_sum_next;
            shape_sum_reg      <= shape_sum_next;
            stab_sq_sum_reg    <= stab_sq_sum_next;
            shape_sq_sum_reg   <= shape_sq_sum_next;
            cross_sum_reg      <= cross_sum_next;
        end
    end

    // Read-back selection.
    always_comb
    begin
        case (s2_sidx_reg)
            SC_FACE_TOTAL:     scalar_sel = DATA_W'(face_total_reg);
            SC_VERTEX_TOTAL:   scalar_sel = DATA_W'(vertex_total_reg);
            SC_ALT_FACE_TOTAL: scalar_sel = DATA_W'(alt_face_total_reg);
            SC_ALT_VERT_TOTAL: scalar_sel = DATA_W'(alt_vert_total_reg);
            SC_STAB_MIN:       scalar_sel = DATA_W'(stab_min_reg);
            SC_STAB_MAX:       scalar_sel = DATA_W'(stab_max_reg);
            SC_SHAPE_MIN:      scalar_sel = DATA_W'(shape_min_reg);
            SC_SHAPE_MAX:      scalar_sel = DATA_W'(shape_max_reg);
            SC_STAB_SUM:       scalar_sel = DATA_W'(stab_sum_reg);
            SC_SHAPE_SUM:      scalar_sel = DATA_W'(shape_sum_reg);
            SC_STAB_SQ_SUM:    scalar_sel = DATA_W'(stab_sq_sum_reg);
            SC_SHAPE_SQ_SUM:   scalar_sel = DATA_W'(shape_sq_sum_reg);
            default:           scalar_sel = DATA_W'(cross_sum_reg);
        endcase
        case (s2_bank_reg)
            BANK_STAB:  read_value = DATA_W'(stab_cur);
            BANK_SHAPE: read_value = DATA_W'(shape_cur);
            BANK_SIDES: read_value = DATA_W'(sides_cur);
            default:    read_value = scalar_sel;
        endcase
        if (s2_oob_reg)
        begin
            read_value = '0;
        end
    end

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance && s2_read)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_read)
        begin
            rsp_reg.read_data   <= read_value;
            rsp_reg.read_status <= s2_oob_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `AFQH_ASSERT_SAME(a_no_accept_while_clearing, clearing_reg, !req_ready,
        "request taken during the clearing pass")
    `AFQH_ASSERT_SAME(a_no_write_while_stalled, stall, !stab_we && !shape_we && !sides_we,
        "histogram written while the pipeline is held")
    `AFQH_ASSERT_SAME(a_extremes_ordered, alt_face_total_reg != '0,
        (stab_min_reg <= stab_max_reg) && (shape_min_reg <= shape_max_reg),
        "minimum above maximum after an altered face")
    `AFQH_ASSERT_NEXT(a_rsp_only_from_read, !rsp_valid_reg && !s2_read, !rsp_valid_reg,
        "response raised without a read beat")

endmodule

// File: dv/tb_altered_face_quality_histogram_top.sv
// ----------------------------------------------------------------------------
// Testbench for the altered face quality histogram
// Drives face, vertex and read beats through the valid/ready request port and
// checks every read beat against a cycle-free predictor of the counters, the
// extremes, the moment sums and the three histograms. Three stretches run
// with different side count offsets and different idling on each side, the
// last of them with one long response stall that backs up the request port.
// ----------------------------------------------------------------------------
module tb_altered_face_quality_histogram_top
    import afqh_pkg::*;
();

    localparam logic [3:0] SC_CROSS_PROD_SUM = 4'd12;
    localparam logic [1:0] REQ_UNUSED        = 2'd3;
    localparam int RANDOM_PER_PHASE = 300;
    localparam int DRAIN_CYCLES     = 10;
    localparam int LONG_HOLD        = 300;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int MAX_GAP          = 12;
    localparam int PRINT_CAP        = 100;

    class histogram_predictor;
        bit [COUNT_BITS-1:0] stab_bins [QUALITY_BINS];
        bit [COUNT_BITS-1:0] shape_bins [QUALITY_BINS];
        bit [COUNT_BITS-1:0] side_bins [SIDE_BINS];
        bit [COUNT_BITS-1:0] faces, vertices, altered_faces, altered_vertices;
        bit [Q_W-1:0]        stab_lo, stab_hi, shape_lo, shape_hi;
        bit [SUM_W-1:0]      stab_total, shape_total;
        bit [SQ_W-1:0]       stab_sq_total, shape_sq_total, cross_total;
        bit [SIDE_W-1:0]     first_side;
        afqh_out_t           pending_reads [$];
        int                  errors;

        function new();
            foreach (stab_bins[i])
            begin
                stab_bins[i]  = '0;
                shape_bins[i] = '0;
            end
            foreach (side_bins[i])
            begin
                side_bins[i] = '0;
            end
            faces            = '0;
            vertices         = '0;
            altered_faces    = '0;
            altered_vertices = '0;
            stab_lo          = '1;
            shape_lo         = '1;
            stab_hi          = '0;
            shape_hi         = '0;
            stab_total       = '0;
            shape_total      = '0;
            stab_sq_total    = '0;
            shape_sq_total   = '0;
            cross_total      = '0;
            first_side       = FIRST_SIDE_RESET;
            errors           = 0;
        endfunction

        function bit [63:0] add_capped(bit [63:0] a, bit [63:0] b, int w);
            bit [63:0] top;
            top = (64'd1 << w) - 64'd1;
            if (a > top || b > top - a)
            begin
                return top;
            end
            return a + b;
        endfunction

        function bit [COUNT_BITS-1:0] bump(bit [COUNT_BITS-1:0] c);
            return COUNT_BITS'(add_capped(64'(c), 64'd1, COUNT_BITS));
        endfunction

        function bit [Q_W-1:0] clamp_quality(bit [Q_W-1:0] q);
            return (q > Q_ONE) ? Q_ONE : q;
        endfunction

        function int bin_of_quality(bit [Q_W-1:0] q);
            bit [63:0] b;
            b = (64'(clamp_quality(q)) * 64'd1000) >> 16;
            if (b >= 64'(QUALITY_BINS))
            begin
                b = 64'(QUALITY_BINS - 1);
            end
            return int'(b);
        endfunction

        function int bin_of_sides(bit [SIDE_W-1:0] sides);
            int d;
            if (sides <= first_side)
            begin
                return 0;
            end
            d = int'(sides) - int'(first_side);
            return (d >= SIDE_BINS) ? SIDE_BINS - 1 : d;
        endfunction

        function bit [DATA_W-1:0] scalar(bit [3:0] sel);
            case (sel)
                SC_FACE_TOTAL:     return DATA_W'(faces);
                SC_VERTEX_TOTAL:   return DATA_W'(vertices);
                SC_ALT_FACE_TOTAL: return DATA_W'(altered_faces);
                SC_ALT_VERT_TOTAL: return DATA_W'(altered_vertices);
                SC_STAB_MIN:       return DATA_W'(stab_lo);
                SC_STAB_MAX:       return DATA_W'(stab_hi);
                SC_SHAPE_MIN:      return DATA_W'(shape_lo);
                SC_SHAPE_MAX:      return DATA_W'(shape_hi);
                SC_STAB_SUM:       return DATA_W'(stab_total);
                SC_SHAPE_SUM:      return DATA_W'(shape_total);
                SC_STAB_SQ_SUM:    return DATA_W'(stab_sq_total);
                SC_SHAPE_SQ_SUM:   return DATA_W'(shape_sq_total);
                default:           return DATA_W'(cross_total);
            endcase
        endfunction

        function void note_beat(afqh_in_t b);
            bit [Q_W-1:0] qs;
            bit [Q_W-1:0] qg;
            afqh_out_t    want;
            int           bs;
            int           bg;
            int           bn;
            case (b.req_type)
                REQ_FACE:
                begin
                    faces = bump(faces);
                    if (b.altered)
                    begin
                        qs = clamp_quality(b.stability_q);
                        qg = clamp_quality(b.shape_q);
                        altered_faces = bump(altered_faces);
                        if (qs < stab_lo) stab_lo = qs;
                        if (qs > stab_hi) stab_hi = qs;
                        if (qg < shape_lo) shape_lo = qg;
                        if (qg > shape_hi) shape_hi = qg;
                        stab_total = SUM_W'(add_capped(64'(stab_total), 64'(qs), SUM_W));
                        shape_total = SUM_W'(add_capped(64'(shape_total), 64'(qg), SUM_W));
                        stab_sq_total = SQ_W'(add_capped(64'(stab_sq_total),
                                                          64'(qs) * 64'(qs), SQ_W));
                        shape_sq_total = SQ_W'(add_capped(64'(shape_sq_total),
                                                           64'(qg) * 64'(qg), SQ_W));
                        cross_total = SQ_W'(add_capped(64'(cross_total),
                                                        64'(qs) * 64'(qg), SQ_W));
                        bs = bin_of_quality(qs);
                        bg = bin_of_quality(qg);
                        bn = bin_of_sides(b.side_count);
                        stab_bins[bs]  = bump(stab_bins[bs]);
                        shape_bins[bg] = bump(shape_bins[bg]);
                        side_bins[bn]  = bump(side_bins[bn]);
                    end
                end
                REQ_VERTEX:
                begin
                    vertices = bump(vertices);
                    if (b.altered)
                    begin
                        altered_vertices = bump(altered_vertices);
                    end
                end
                REQ_READ:
                begin
                    want.read_data   = '0;
                    want.read_status = 1'b0;
                    case (b.read_bank)
                        BANK_STAB:
                            if (b.read_index < QUALITY_BINS)
                                want.read_data = DATA_W'(stab_bins[b.read_index]);
                            else
                                want.read_status = 1'b1;
                        BANK_SHAPE:
                            if (b.read_index < QUALITY_BINS)
                                want.read_data = DATA_W'(shape_bins[b.read_index]);
                            else
                                want.read_status = 1'b1;
                        BANK_SIDES:
                            if (b.read_index < SIDE_BINS)
                                want.read_data = DATA_W'(side_bins[b.read_index]);
                            else
                                want.read_status = 1'b1;
                        default:
                            if (b.read_index < SCALAR_COUNT)
                                want.read_data = scalar(b.read_index[3:0]);
                            else
                                want.read_status = 1'b1;
                    endcase
                    pending_reads = {pending_reads, want};
                end
                default:
                begin
                end
            endcase
        endfunction

        task flag(string what);
            if (errors < PRINT_CAP)
            begin
                $display("mismatch at %0t: %s", $realtime, what);
            end
            errors++;
        endtask

        task check_read(afqh_out_t got);
            afqh_out_t want;
            if (pending_reads.size() == 0)
            begin
                flag($sformatf("unexpected read beat data %h status %b",
                               got.read_data, got.read_status));
                return;
            end
            want = pending_reads.pop_front();
            if (got.read_data !== want.read_data)
            begin
                flag($sformatf("read_data %h, wanted %h", got.read_data, want.read_data));
            end
            if (got.read_status !== want.read_status)
            begin
                flag($sformatf("read_status %b, wanted %b",
                               got.read_status, want.read_status));
            end
        endtask

        function int pending();
            return pending_reads.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    afqh_in_t          req;
    logic              rsp_valid;
    logic              rsp_ready;
    afqh_out_t         rsp;
    logic              cfg_wr_en;
    logic [SIDE_W-1:0] cfg_wr_data;

    histogram_predictor board;
    int                 tx_idle_pct;
    int                 rx_idle_pct;
    bit                 long_hold_go   = 1'b0;
    bit                 long_hold_done = 1'b0;
    int                 hold_count     = 0;
    int                 cycle_count    = 0;
    int                 recent_bins [$];

    altered_face_quality_histogram_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (long_hold_go && !long_hold_done)
        begin
            rsp_ready  <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count == LONG_HOLD - 1)
            begin
                long_hold_done <= 1'b1;
            end
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            board.check_read(rsp);
        end
    end

    function automatic afqh_in_t make_beat(logic [1:0] kind, logic alt, logic [Q_W-1:0] qs,
                                           logic [Q_W-1:0] qg, logic [SIDE_W-1:0] sides,
                                           logic [1:0] bank, logic [IDX_W-1:0] idx);
        afqh_in_t b;
        b.req_type    = kind;
        b.altered     = alt;
        b.stability_q = qs;
        b.shape_q     = qg;
        b.side_count  = sides;
        b.read_bank   = bank;
        b.read_index  = idx;
        return b;
    endfunction

    function automatic logic [Q_W-1:0] pick_quality();
        int r;
        r = $urandom_range(99);
        if (r < 70) return Q_W'($urandom_range(65536));
        if (r < 80) return Q_ONE;
        if (r < 88) return Q_W'($urandom_range(131071, 65537));
        if (r < 95) return Q_W'($urandom_range(100));
        return Q_W'($urandom_range(131071));
    endfunction

    function automatic afqh_in_t random_beat();
        afqh_in_t b;
        int       r;
        b = make_beat(2'($urandom_range(3)), 1'($urandom_range(1)),
                      Q_W'($urandom_range(131071)), Q_W'($urandom_range(131071)),
                      SIDE_W'($urandom_range(255)), 2'($urandom_range(3)),
                      IDX_W'($urandom_range(1023)));
        r = $urandom_range(99);
        if (r < 45)
        begin
            b.req_type    = REQ_FACE;
            b.altered     = ($urandom_range(3) != 0);
            b.stability_q = pick_quality();
            b.shape_q     = pick_quality();
            if ($urandom_range(99) < 70)
            begin
                b.side_count = board.first_side + SIDE_W'($urandom_range(52)) - SIDE_W'(2);
            end
            if (b.altered)
            begin
                recent_bins = {recent_bins, board.bin_of_quality(b.stability_q),
                               board.bin_of_quality(b.shape_q)};
                while (recent_bins.size() > 16)
                begin
                    void'(recent_bins.pop_front());
                end
            end
        end
        else if (r < 60)
        begin
            b.req_type = REQ_VERTEX;
        end
        else if (r < 95)
        begin
            b.req_type = REQ_READ;
            r = $urandom_range(99);
            case (b.read_bank)
                BANK_STAB, BANK_SHAPE:
                    if (r < 80 && recent_bins.size() > 0)
                        b.read_index = IDX_W'(recent_bins[$urandom_range(recent_bins.size() - 1)]);
                    else if (r < 90)
                        b.read_index = IDX_W'($urandom_range(QUALITY_BINS - 1));
                BANK_SIDES:
                    if (r < 80)
                        b.read_index = IDX_W'($urandom_range(SIDE_BINS - 1));
                default:
                    if (r < 85)
                        b.read_index = IDX_W'($urandom_range(SCALAR_COUNT - 1));
            endcase
        end
        else
        begin
            b.req_type = REQ_UNUSED;
        end
        return b;
    endfunction

    task automatic drive_beat(input afqh_in_t b);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= b;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        board.note_beat(b);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_first_side(input logic [SIDE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.first_side = value;
    endtask

    task automatic run_directed();
        afqh_in_t plan [$];
        plan = {plan, make_beat(REQ_READ, 1'b0, '0, '0, '0, BANK_SCALAR,
                                IDX_W'(SC_STAB_MIN))};
        plan = {plan, make_beat(REQ_READ, 1'b0, '0, '0, '0, BANK_SCALAR,
                                IDX_W'(SC_SHAPE_MAX))};
        plan = {plan, make_beat(REQ_FACE, 1'b0, '1, '1, 8'd9, BANK_STAB, '0)};
        plan = {plan, make_beat(REQ_FACE, 1'b1, '0, Q_ONE, 8'd0, BANK_STAB, '0)};
        plan = {plan, make_beat(REQ_FACE, 1'b1, '1, 17'd65535, 8'd255, BANK_STAB, '0)};
        plan = {plan, make_beat(REQ_FACE, 1'b1, 17'd65535, 17'd1, 8'd3, BANK_STAB, '0)};
        plan = {plan, make_beat(REQ_VERTEX, 1'b1, '1, '1, '1, '1, '1)};
        plan = {plan, make_beat(REQ_VERTEX, 1'b0, '0, '0, '0, '0, '0)};
        plan = {plan, make_beat(REQ_UNUSED, 1'b1, '1, '1, '1, '1, '1)};
        plan = {plan, make_beat(REQ_READ, 1'b0, '0, '0, '0, BANK_STAB, IDX_W'(0))};
        plan = {plan, make_beat(REQ_READ, 1'b0, '0, '0, '0, BANK_STAB, IDX_W'(999))};
        plan = {plan, make_beat(REQ_READ, 1'b0, '0, '0, '0, BANK_STAB, IDX_W'(1023))};
        plan = {plan, make_beat(REQ_READ, 1'b0, '0, '0, '0, BANK_SHAPE, IDX_W'(999))};
        plan = {plan, make_beat(REQ_READ, 1'b0, '0, '0, '0, BANK_SHAPE, IDX_W'(1000))};
        plan = {plan, make_beat(REQ_READ, 1'b0, '0, '0, '0, BANK_SIDES, IDX_W'(0))};
        plan = {plan, make_beat(REQ_READ, 1'b0, '0, '0, '0, BANK_SIDES, IDX_W'(47))};
        plan = {plan, make_beat(REQ_READ, 1'b0, '0, '0, '0, BANK_SIDES, IDX_W'(48))};
        plan = {plan, make_beat(REQ_READ, 1'b0, '0, '0, '0, BANK_SCALAR,
                                IDX_W'(SC_FACE_TOTAL))};
        plan = {plan, make_beat(REQ_READ, 1'b0, '0, '0, '0, BANK_SCALAR,
                                IDX_W'(SC_STAB_SUM))};
        plan = {plan, make_beat(REQ_READ, 1'b0, '0, '0, '0, BANK_SCALAR,
                                IDX_W'(SC_CROSS_PROD_SUM))};
        plan = {plan, make_beat(REQ_READ, 1'b0, '0, '0, '0, BANK_SCALAR, IDX_W'(13))};
        plan = {plan, make_beat(REQ_READ, 1'b0, '0, '0, '0, BANK_SCALAR, IDX_W'(1023))};
        foreach (plan[i])
        begin
            drive_beat(plan[i]);
        end
    endtask

    task automatic run_random(input int count);
        repeat (count)
        begin
            drive_beat(random_beat());
        end
    endtask

    initial
    begin
        board       = new();
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        rsp_ready   = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        settle();

        write_first_side(8'd0);
        tx_idle_pct = 35;
        rx_idle_pct = 55;
        run_random(RANDOM_PER_PHASE);
        settle();

        write_first_side(8'd255);
        tx_idle_pct = 55;
        rx_idle_pct = 35;
        run_random(RANDOM_PER_PHASE);
        settle();

        write_first_side(SIDE_W'($urandom_range(254, 1)));
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        long_hold_go = 1'b1;
        run_random(RANDOM_PER_PHASE);
        settle();

        if (board.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
